[hdl/wtsp_pkg.sv]
// Shared types and constants for the world-to-screen projection core.
// Used by every module under hdl; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package wtsp_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WORD_W    = 32;
  localparam int CFG_W     = 64;
  localparam int SIZE_W    = 14;
  localparam int CFG_IDX_W = 3;

  localparam int PROD_W  = 2 * WORD_W;
  localparam int SUM_W   = PROD_W + 2;
  localparam int CLIP_W  = SUM_W - FRAC_BITS;
  localparam int MAG_W   = CLIP_W + 1;
  localparam int ALO_W   = (MAG_W + 1) / 2;
  localparam int AHI_W   = MAG_W - ALO_W;
  localparam int K_W     = SIZE_W + FRAC_BITS - 1;
  localparam int NUM_W   = MAG_W + K_W;
  localparam int DIV_STEPS = WORD_W;

  localparam int THR_RAW = ((1 << FRAC_BITS) + 500) / 1000;
  localparam int THR_INT = (THR_RAW < 1) ? 1 : THR_RAW;
  localparam logic signed [CLIP_W-1:0] VIS_THR = CLIP_W'(THR_INT);

  localparam logic [SIZE_W-1:0] WIDTH_RST  = SIZE_W'(1920);
  localparam logic [SIZE_W-1:0] HEIGHT_RST = SIZE_W'(1080);

  localparam logic [WORD_W-1:0] SAT_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic [WORD_W-1:0] SAT_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW0_01 = 3'd0,
    CFG_ROW0_23 = 3'd1,
    CFG_ROW1_01 = 3'd2,
    CFG_ROW1_23 = 3'd3,
    CFG_ROW3_01 = 3'd4,
    CFG_ROW3_23 = 3'd5,
    CFG_WIDTH   = 3'd6,
    CFG_HEIGHT  = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic signed [WORD_W-1:0] point_x;
    logic signed [WORD_W-1:0] point_y;
    logic signed [WORD_W-1:0] point_z;
  } point_t;

  typedef struct packed {
    logic                     visible;
    logic signed [WORD_W-1:0] screen_x;
    logic signed [WORD_W-1:0] screen_y;
  } result_t;

  typedef struct packed {
    logic [CFG_W-1:0] cols_01;
    logic [CFG_W-1:0] cols_23;
  } row_t;

endpackage
`default_nettype wire

[hdl/wtsp_row_eval.sv]
// One matrix row dotted with (x, y, z, 1), floored to FRAC_BITS fraction bits.
// Two register stages: products, then sum. Depends on wtsp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module wtsp_row_eval (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  wtsp_pkg::point_t              point_i,
  input  wtsp_pkg::row_t                row_i,
  output logic                          valid_o,
  output logic signed [wtsp_pkg::CLIP_W-1:0] clip_o
);
  import wtsp_pkg::*;

  logic signed [WORD_W-1:0] m0, m1, m2, m3;
  logic signed [PROD_W-1:0] p0_q, p1_q, p2_q;
  logic signed [SUM_W-1:0]  sum_d;
  logic signed [CLIP_W-1:0] clip_q;
  logic                     v1_q, v2_q;

  assign m0 = $signed(row_i.cols_01[WORD_W-1:0]);
  assign m1 = $signed(row_i.cols_01[CFG_W-1:WORD_W]);
  assign m2 = $signed(row_i.cols_23[WORD_W-1:0]);
  assign m3 = $signed(row_i.cols_23[CFG_W-1:WORD_W]);

  assign sum_d = SUM_W'(p0_q) + SUM_W'(p1_q) + SUM_W'(p2_q)
               + (SUM_W'(m3) <<< FRAC_BITS);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p0_q   <= m0 * point_i.point_x;
      p1_q   <= m1 * point_i.point_y;
      p2_q   <= m2 * point_i.point_z;
      clip_q <= sum_d[SUM_W-1:FRAC_BITS];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  assign valid_o = v2_q;
  assign clip_o  = clip_q;

endmodule
`default_nettype wire

[hdl/wtsp_scale.sv]
// Numerator w +/- c, magnitude times the viewport scale, overflow check.
// Three register stages feeding the divider. Depends on wtsp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module wtsp_scale (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  logic                               sub_i,
  input  logic signed [wtsp_pkg::CLIP_W-1:0] w_i,
  input  logic signed [wtsp_pkg::CLIP_W-1:0] c_i,
  input  logic [wtsp_pkg::SIZE_W-1:0]        size_i,
  output logic                               valid_o,
  output logic                               vis_o,
  output logic                               neg_o,
  output logic                               ovf_o,
  output logic [wtsp_pkg::CLIP_W-1:0]        rem_o,
  output logic [wtsp_pkg::WORD_W-1:0]        low_o,
  output logic [wtsp_pkg::CLIP_W-1:0]        div_o
);
  import wtsp_pkg::*;

  logic signed [MAG_W-1:0] n_d;
  logic [MAG_W-1:0]        a_d, a_q;
  logic [K_W-1:0]          k;
  logic [ALO_W+K_W-1:0]    plo_q;
  logic [AHI_W+K_W-1:0]    phi_q;
  logic [NUM_W-1:0]        num_d;
  logic [CLIP_W-1:0]       d1_q, d2_q, d3_q;
  logic                    n1_q, n2_q, n3_q, s1_q, s2_q, s3_q, ovf_q;
  logic [CLIP_W-1:0]       rem_q;
  logic [WORD_W-1:0]       low_q;
  logic                    v1_q, v2_q, v3_q;

  assign n_d = sub_i ? (MAG_W'(w_i) - MAG_W'(c_i)) : (MAG_W'(w_i) + MAG_W'(c_i));
  assign a_d = n_d[MAG_W-1] ? MAG_W'(-n_d) : MAG_W'(n_d);
  assign k   = K_W'(size_i) << (FRAC_BITS - 1);
  assign num_d = (NUM_W'(phi_q) << ALO_W) + NUM_W'(plo_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q   <= a_d;
      n1_q  <= n_d[MAG_W-1];
      s1_q  <= (w_i >= VIS_THR);
      d1_q  <= CLIP_W'(w_i);
      plo_q <= (ALO_W+K_W)'(a_q[ALO_W-1:0]) * (ALO_W+K_W)'(k);
      phi_q <= (AHI_W+K_W)'(a_q[MAG_W-1:ALO_W]) * (AHI_W+K_W)'(k);
      n2_q  <= n1_q;
      s2_q  <= s1_q;
      d2_q  <= d1_q;
      ovf_q <= (CLIP_W+1)'(num_d[NUM_W-1:WORD_W]) >= (CLIP_W+1)'(d2_q);
      rem_q <= CLIP_W'(num_d[NUM_W-1:WORD_W]);
      low_q <= num_d[WORD_W-1:0];
      n3_q  <= n2_q;
      s3_q  <= s2_q;
      d3_q  <= d2_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  assign valid_o = v3_q;
  assign vis_o   = s3_q;
  assign neg_o   = n3_q;
  assign ovf_o   = ovf_q;
  assign rem_o   = rem_q;
  assign low_o   = low_q;
  assign div_o   = d3_q;

endmodule
`default_nettype wire

[hdl/wtsp_div_pipe.sv]
// Pipelined restoring divider, one quotient bit per stage, with saturation
// to signed 32 bits on the way out. Depends on wtsp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module wtsp_div_pipe (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic                        vis_i,
  input  logic                        neg_i,
  input  logic                        ovf_i,
  input  logic [wtsp_pkg::CLIP_W-1:0] rem_i,
  input  logic [wtsp_pkg::WORD_W-1:0] low_i,
  input  logic [wtsp_pkg::CLIP_W-1:0] div_i,
  output logic                        valid_o,
  output logic                        vis_o,
  output logic [wtsp_pkg::WORD_W-1:0] res_o
);
  import wtsp_pkg::*;

  logic [CLIP_W-1:0] r_q   [DIV_STEPS];
  logic [WORD_W-1:0] low_q [DIV_STEPS];
  logic [WORD_W-1:0] q_q   [DIV_STEPS];
  logic [CLIP_W-1:0] d_q   [DIV_STEPS];
  logic              neg_q [DIV_STEPS];
  logic              ovf_q [DIV_STEPS];
  logic              vis_q [DIV_STEPS];
  logic              v_q   [DIV_STEPS];

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
    logic [CLIP_W-1:0] r_src, d_src;
    logic [WORD_W-1:0] low_src, q_src;
    logic              neg_src, ovf_src, vis_src, v_src, ge;
    logic [CLIP_W:0]   t;

    if (s == 0) begin : g_first
      assign r_src   = rem_i;
      assign d_src   = div_i;
      assign low_src = low_i;
      assign q_src   = '0;
      assign neg_src = neg_i;
      assign ovf_src = ovf_i;
      assign vis_src = vis_i;
      assign v_src   = valid_i;
    end else begin : g_next
      assign r_src   = r_q[s-1];
      assign d_src   = d_q[s-1];
      assign low_src = low_q[s-1];
      assign q_src   = q_q[s-1];
      assign neg_src = neg_q[s-1];
      assign ovf_src = ovf_q[s-1];
      assign vis_src = vis_q[s-1];
      assign v_src   = v_q[s-1];
    end

    assign t  = {r_src, low_src[WORD_W-1]};
    assign ge = t >= {1'b0, d_src};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[s]   <= ge ? CLIP_W'(t - {1'b0, d_src}) : t[CLIP_W-1:0];
        low_q[s] <= low_src << 1;
        q_q[s]   <= {q_src[WORD_W-2:0], ge};
        d_q[s]   <= d_src;
        neg_q[s] <= neg_src;
        ovf_q[s] <= ovf_src;
        vis_q[s] <= vis_src;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= v_src;
      end
    end
  end

  logic [WORD_W-1:0] q;
  logic [WORD_W:0]   mag;
  logic              sat;

  assign q   = q_q[DIV_STEPS-1];
  assign sat = ovf_q[DIV_STEPS-1];
  assign mag = {1'b0, q} + (WORD_W+1)'(r_q[DIV_STEPS-1] != '0);

  always_comb begin
    if (!vis_q[DIV_STEPS-1]) begin
      res_o = '0;
    end else if (!neg_q[DIV_STEPS-1]) begin
      res_o = (sat || q[WORD_W-1]) ? SAT_MAX : q;
    end else if (sat || mag > {1'b0, SAT_MIN}) begin
      res_o = SAT_MIN;
    end else begin
      res_o = WORD_W'(-mag);
    end
  end

  assign valid_o = v_q[DIV_STEPS-1];
  assign vis_o   = vis_q[DIV_STEPS-1];

endmodule
`default_nettype wire

[hdl/world_to_screen_projection_core.sv]
// Path from input transfer to result valid: row evaluation, scale, divider,
// output register. Throughput: one point per cycle; a stalled output
// freezes the whole pipeline, so nothing is lost or repeated.
// Reset: asynchronous active low, clears valids and loads matrix 0,
// viewport 1920 x 1080. Depends on wtsp_pkg and all wtsp_* modules.
`timescale 1ns / 1ps
`default_nettype none
module world_to_screen_projection_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  wtsp_pkg::point_t               in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output wtsp_pkg::result_t              out_data_o,
  input  logic                           cfg_we_i,
  input  logic [wtsp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [wtsp_pkg::CFG_W-1:0]     cfg_data_i
);
  import wtsp_pkg::*;

  row_t              row0_q, row1_q, row3_q;
  logic [SIZE_W-1:0] width_q, height_q;
  logic              en;
  logic              out_valid_q;
  result_t           out_data_q;

  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row0_q   <= '0;
      row1_q   <= '0;
      row3_q   <= '0;
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ROW0_01: row0_q.cols_01 <= cfg_data_i;
        CFG_ROW0_23: row0_q.cols_23 <= cfg_data_i;
        CFG_ROW1_01: row1_q.cols_01 <= cfg_data_i;
        CFG_ROW1_23: row1_q.cols_23 <= cfg_data_i;
        CFG_ROW3_01: row3_q.cols_01 <= cfg_data_i;
        CFG_ROW3_23: row3_q.cols_23 <= cfg_data_i;
        CFG_WIDTH:   width_q  <= cfg_data_i[SIZE_W-1:0];
        CFG_HEIGHT:  height_q <= cfg_data_i[SIZE_W-1:0];
      endcase
    end
  end

  logic                     row_valid, row_valid_y, row_valid_w;
  logic signed [CLIP_W-1:0] cx, cy, w;

  wtsp_row_eval u_row_x (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i), .point_i(in_data_i),
    .row_i(row0_q), .valid_o(row_valid), .clip_o(cx)
  );
  wtsp_row_eval u_row_y (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i), .point_i(in_data_i),
    .row_i(row1_q), .valid_o(row_valid_y), .clip_o(cy)
  );
  wtsp_row_eval u_row_w (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i), .point_i(in_data_i),
    .row_i(row3_q), .valid_o(row_valid_w), .clip_o(w)
  );

  logic              sx_valid, sx_vis, sx_neg, sx_ovf;
  logic              sy_valid, sy_vis, sy_neg, sy_ovf;
  logic [CLIP_W-1:0] sx_rem, sx_div, sy_rem, sy_div;
  logic [WORD_W-1:0] sx_low, sy_low;

  wtsp_scale u_scale_x (
    .clk_i, .rst_ni, .en_i(en), .valid_i(row_valid), .sub_i(1'b0),
    .w_i(w), .c_i(cx), .size_i(width_q),
    .valid_o(sx_valid), .vis_o(sx_vis), .neg_o(sx_neg), .ovf_o(sx_ovf),
    .rem_o(sx_rem), .low_o(sx_low), .div_o(sx_div)
  );
  wtsp_scale u_scale_y (
    .clk_i, .rst_ni, .en_i(en), .valid_i(row_valid), .sub_i(1'b1),
    .w_i(w), .c_i(cy), .size_i(height_q),
    .valid_o(sy_valid), .vis_o(sy_vis), .neg_o(sy_neg), .ovf_o(sy_ovf),
    .rem_o(sy_rem), .low_o(sy_low), .div_o(sy_div)
  );

  logic              dx_valid, dx_vis, dy_valid, dy_vis;
  logic [WORD_W-1:0] dx_res, dy_res;

  wtsp_div_pipe u_div_x (
    .clk_i, .rst_ni, .en_i(en), .valid_i(sx_valid), .vis_i(sx_vis),
    .neg_i(sx_neg), .ovf_i(sx_ovf), .rem_i(sx_rem), .low_i(sx_low),
    .div_i(sx_div), .valid_o(dx_valid), .vis_o(dx_vis), .res_o(dx_res)
  );
  wtsp_div_pipe u_div_y (
    .clk_i, .rst_ni, .en_i(en), .valid_i(sy_valid), .vis_i(sy_vis),
    .neg_i(sy_neg), .ovf_i(sy_ovf), .rem_i(sy_rem), .low_i(sy_low),
    .div_i(sy_div), .valid_o(dy_valid), .vis_o(dy_vis), .res_o(dy_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dx_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q.visible  <= dx_vis;
      out_data_q.screen_x <= $signed(dx_res);
      out_data_q.screen_y <= $signed(dy_res);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_lanes_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_valid == row_valid_y) && (row_valid == row_valid_w)
    && (sx_valid == sy_valid) && (dx_valid == dy_valid) && (dx_vis == dy_vis))
    else $error("projection lanes out of step");

  a_hidden_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.visible |-> out_data_o.screen_x == 0
    && out_data_o.screen_y == 0)
    else $error("hidden point with nonzero screen value");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held result");

endmodule
`default_nettype wire
